### hw/rtl/dssf_pkg.sv
// Shared constants, register indexes and helpers for the decimating scope sample framer.
// No dependencies; imported by dssf_scale and decimating_scope_sample_framer_core.
package dssf_pkg;

    localparam int FIFO_DEPTH    = 64;
    localparam int CHANNEL_COUNT = 8;
    localparam int SAMPLE_WIDTH  = 16;

    localparam int OUT_CHANNELS = 8;
    localparam int IN_SAMPLE_W  = 16;
    localparam int COEF_W       = 16;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 3;
    localparam int TICK_W       = 16;
    localparam int BYTE_W       = 8;
    localparam int FRAC_W       = 16;

    localparam int PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int ROW_W  = CHANNEL_COUNT * SAMPLE_WIDTH;
    localparam int SUM_W  = ((SAMPLE_WIDTH > COEF_W) ? SAMPLE_WIDTH : COEF_W) + 1;
    localparam int PROD_W = SUM_W + COEF_W;
    localparam int VAL_W  = PROD_W + 1;

    localparam int OUT_BIAS = 128;
    localparam int BYTE_MIN = 1;
    localparam int BYTE_MAX = 254;

    localparam logic [TICK_W-1:0]     STEP_RESET = TICK_W'(50);
    localparam logic [CFG_DATA_W-1:0] GAIN_RESET = 64'h0A00_0A00_0A00_0A00;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DECIMATION_STEP = 3'd0,
        REG_OFFSETS_LOW     = 3'd1,
        REG_OFFSETS_HIGH    = 3'd2,
        REG_GAINS_LOW       = 3'd3,
        REG_GAINS_HIGH      = 3'd4
    } cfg_reg_t;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Ring pointer increment, wraps at FIFO_DEPTH.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

### hw/rtl/dssf_scale.sv
// One channel lane: registered (sample + offset) * gain, then bias and clamp to 1..254.
// Depends on dssf_pkg.
module dssf_scale
    import dssf_pkg::*;
(
    input  logic                           aclk,
    input  logic                           load,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic signed [COEF_W-1:0]       offset,
    input  logic signed [COEF_W-1:0]       gain,
    output logic [BYTE_W-1:0]              byte_out
);

    localparam logic signed [VAL_W-1:0] BIAS_Q   = VAL_W'(OUT_BIAS) <<< FRAC_W;
    localparam logic signed [VAL_W-1:0] LOW_LIM  = VAL_W'(1) <<< FRAC_W;
    localparam logic signed [VAL_W-1:0] HIGH_LIM = VAL_W'(BYTE_MAX + 1) <<< FRAC_W;

    logic signed [SUM_W-1:0]  sum;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [VAL_W-1:0]  val;

    assign sum  = SUM_W'(sample) + SUM_W'(offset);
    assign prod = PROD_W'(sum) * PROD_W'(gain);

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= prod;
        end
    end

    assign val = VAL_W'(prod_reg) + BIAS_Q;

    always_comb begin
        if (val < LOW_LIM) begin
            byte_out = BYTE_W'(BYTE_MIN);
        end else if (val >= HIGH_LIM) begin
            byte_out = BYTE_W'(BYTE_MAX);
        end else begin
            byte_out = val[FRAC_W +: BYTE_W];
        end
    end

endmodule

### hw/rtl/decimating_scope_sample_framer_core.sv
// Decimating scope sample framer: tick decimation into a sample ring, drain to scaled frames.
// Depends on dssf_pkg and dssf_scale.
//
// Input words (s_*): tuser[0] selects tick (0) or drain (1); tuser[1] is link-up for a
// drain. A tick carries eight Q8.8 samples in tdata; every decimation_step ticks (every
// tick when the step is 0) the set is written to a FIFO_DEPTH-row ring, unless that
// would fill it, in which case it is dropped.
// A drain pops every stored row. With the link up and a nonzero step, each row becomes
// one output word: eight bytes of (sample + offset) * gain + 128 clamped to 1..254,
// with tlast on the final row; otherwise the stored rows are discarded. Each frame
// steps through ST_READ (ring read), ST_MUL (lane multiply) and ST_OUT (clamp into the
// output register); the sequencer takes one row at a time and reads the next only
// once a frame is loaded. A stalled receiver holds the sequencer in its output step;
// s_tready is low for the whole drain and returns once the last frame is in the
// output register, which may still be waiting on m_tready. Reset clears the pointers,
// tick counter, state and output flags and loads the config reset values; ring rows
// are not cleared and are only read after being written. Config writes are registered.
module decimating_scope_sample_framer_core
    import dssf_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_wdata,

    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [IN_SAMPLE_W*8-1:0]     s_tdata,   // sample_0 .. sample_7
    input  logic [1:0]                   s_tuser,   // operation, link_connected

    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [BYTE_W*OUT_CHANNELS-1:0] m_tdata, // byte_0 .. byte_7
    output logic                         m_tlast    // last_frame
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_OUT
    } state_t;

    state_t                   state_reg;
    logic [TICK_W-1:0]        step_reg;
    logic [CFG_DATA_W-1:0]    offsets_low_reg;
    logic [CFG_DATA_W-1:0]    offsets_high_reg;
    logic [CFG_DATA_W-1:0]    gains_low_reg;
    logic [CFG_DATA_W-1:0]    gains_high_reg;
    logic [TICK_W-1:0]        tick_counter_reg;
    logic [PTR_W-1:0]         write_index_reg;
    logic [PTR_W-1:0]         read_index_reg;
    logic [ROW_W-1:0]         rd_row_reg;
    logic                     m_tvalid_reg;
    logic                     m_tlast_reg;
    logic [BYTE_W*OUT_CHANNELS-1:0] m_tdata_reg;

    logic [ROW_W-1:0]         store_mem [FIFO_DEPTH];

    logic                     in_fire;
    logic                     is_drain;
    logic                     send;
    logic                     due;
    logic                     ring_full;
    logic                     store_wr;
    logic [ROW_W-1:0]         wr_row;
    logic [PTR_W-1:0]         read_index_next;
    logic                     out_load;
    logic                     frame_last;
    logic [2*CFG_DATA_W-1:0]  offsets_all;
    logic [2*CFG_DATA_W-1:0]  gains_all;
    logic [BYTE_W-1:0]        lane_byte [OUT_CHANNELS];
    logic [BYTE_W*OUT_CHANNELS-1:0] frame_data;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign is_drain = (s_tuser[0] == OP_DRAIN);
    assign send     = s_tuser[1] && (step_reg != '0);

    assign due       = (step_reg == '0) || (tick_counter_reg >= step_reg - TICK_W'(1));
    assign ring_full = (ptr_inc(write_index_reg) == read_index_reg);
    assign store_wr  = in_fire && (s_tuser[0] == OP_TICK) && due && !ring_full;

    assign read_index_next = ptr_inc(read_index_reg);
    assign frame_last      = (read_index_next == write_index_reg);
    assign out_load        = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    assign offsets_all = {offsets_high_reg, offsets_low_reg};
    assign gains_all   = {gains_high_reg, gains_low_reg};

    always_comb begin
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
            wr_row[c*SAMPLE_WIDTH +: SAMPLE_WIDTH] =
                SAMPLE_WIDTH'($signed(s_tdata[c*IN_SAMPLE_W +: IN_SAMPLE_W]));
        end
    end

    // Config registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg         <= STEP_RESET;
            offsets_low_reg  <= '0;
            offsets_high_reg <= '0;
            gains_low_reg    <= GAIN_RESET;
            gains_high_reg   <= GAIN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DECIMATION_STEP: step_reg         <= cfg_wdata[TICK_W-1:0];
                REG_OFFSETS_LOW:     offsets_low_reg  <= cfg_wdata;
                REG_OFFSETS_HIGH:    offsets_high_reg <= cfg_wdata;
                REG_GAINS_LOW:       gains_low_reg    <= cfg_wdata;
                REG_GAINS_HIGH:      gains_high_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sample ring: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (store_wr) begin
            store_mem[write_index_reg] <= wr_row;
        end
        if (state_reg == ST_READ) begin
            rd_row_reg <= store_mem[read_index_reg];
        end
    end

    // Channel lanes.
    for (genvar c = 0; c < OUT_CHANNELS; c++) begin : g_lane
        if (c < CHANNEL_COUNT) begin : g_used
            dssf_scale u_scale (
                .aclk     (aclk),
                .load     (state_reg == ST_MUL),
                .sample   ($signed(rd_row_reg[c*SAMPLE_WIDTH +: SAMPLE_WIDTH])),
                .offset   ($signed(offsets_all[c*COEF_W +: COEF_W])),
                .gain     ($signed(gains_all[c*COEF_W +: COEF_W])),
                .byte_out (lane_byte[c])
            );
        end else begin : g_unused
            assign lane_byte[c] = '0;
        end
        assign frame_data[c*BYTE_W +: BYTE_W] = lane_byte[c];
    end

    // Sequencer, pointers, tick counter and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            tick_counter_reg <= '0;
            write_index_reg  <= '0;
            read_index_reg   <= '0;
            m_tvalid_reg     <= 1'b0;
            m_tlast_reg      <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        if (is_drain) begin
                            if (send && (read_index_reg != write_index_reg)) begin
                                state_reg <= ST_READ;
                            end else begin
                                read_index_reg <= write_index_reg;
                            end
                        end else if (due) begin
                            // counter restarts even when the ring is full
                            tick_counter_reg <= '0;
                            if (!ring_full) begin
                                write_index_reg <= ptr_inc(write_index_reg);
                            end
                        end else begin
                            tick_counter_reg <= tick_counter_reg + TICK_W'(1);
                        end
                    end
                end
                ST_READ: state_reg <= ST_MUL;
                ST_MUL:  state_reg <= ST_OUT;
                ST_OUT: begin
                    if (out_load) begin
                        m_tvalid_reg   <= 1'b1;
                        m_tlast_reg    <= frame_last;
                        m_tdata_reg    <= frame_data;
                        read_index_reg <= read_index_next;
                        state_reg      <= frame_last ? ST_IDLE : ST_READ;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Assertions

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(write_index_reg) < FIFO_DEPTH) && (int'(read_index_reg) < FIFO_DEPTH))
        else $error("ring pointer out of range");

    a_frame_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (read_index_reg != write_index_reg))
        else $error("frame emitted from empty ring");

    a_last_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && frame_last) |=> (read_index_reg == write_index_reg) && m_tlast)
        else $error("drain ended with rows left or tlast missing");

    a_discard_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && is_drain && !send) |=> (read_index_reg == write_index_reg)
            && (state_reg == ST_IDLE))
        else $error("discarding drain left rows in ring");

endmodule

### dv/decimating_scope_sample_framer_core_tb.sv
// Self-checking bench for decimating_scope_sample_framer_core: a directed table, then random
// tick bursts and drains under several register settings, frames checked against a local model.
// Depends on dssf_pkg and the core RTL only.
module decimating_scope_sample_framer_core_tb;
    import dssf_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 12;
    localparam int RAND_ITEMS  = 320;
    localparam int PHASE_ITEMS = 40;
    localparam int IN_LANES    = 8;

    // indexes past the register list; writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd5;

    localparam int LANES_MILD = 0;
    localparam int LANES_ANY  = 1;
    localparam int LANES_MAX  = 2;
    localparam int LANES_MIN  = 3;

    typedef logic [IN_LANES-1:0][IN_SAMPLE_W-1:0] sample_set_t;

    typedef struct packed {
        logic                                last;
        logic [OUT_CHANNELS-1:0][BYTE_W-1:0] bytes;
    } frame_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_TICK, ROW_DRAIN} row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_INDEX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0]   val;
        logic                    link;
        sample_set_t             smp;
        logic                    pinned;
        frame_t                  want;
    } row_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0]           cfg_index = '0;
    logic [CFG_DATA_W-1:0]            cfg_wdata = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [IN_SAMPLE_W*8-1:0]         s_tdata = '0;   // sample_0 .. sample_7
    logic [1:0]                       s_tuser = '0;   // operation, link_connected
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [BYTE_W*OUT_CHANNELS-1:0]   m_tdata;        // byte_0 .. byte_7
    logic                             m_tlast;        // last_frame

    // model of the block
    logic [TICK_W-1:0]       step_reg;
    logic [CFG_DATA_W-1:0]   off_lo, off_hi, gain_lo, gain_hi;
    logic [TICK_W-1:0]       tick_cnt;
    logic [PTR_W-1:0]        wr_ptr, rd_ptr;
    logic [SAMPLE_WIDTH-1:0] ring_copy [FIFO_DEPTH][CHANNEL_COUNT];
    frame_t                  frames_due[$];

    logic   pinned_on = 1'b0;
    frame_t pinned_frame = '0;
    bit     calm = 1'b0;
    int     mismatches = 0;
    int     cycle_no = 0;
    int     hold_left = 0;
    row_t   directed_rows[$];

    decimating_scope_sample_framer_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic flag_mismatch(input string what, input int lane_no,
                                 input logic [63:0] got, input logic [63:0] want);
        $display("cycle %0d: %s mismatch, lane %0d: got %0h want %0h",
                 cycle_no, what, lane_no, got, want);
        mismatches++;
    endtask

    // Advances the model by one accepted word and queues the frames it yields.
    task automatic predict_framer_word(input logic op, input logic link, input sample_set_t smp);
        frame_t            f;
        int                nxt, held, k, ch, slot;
        longint            s, o, g, acc;
        logic [CFG_DATA_W-1:0] ow, gw;
        if (op == OP_TICK) begin
            if (step_reg != 0 && int'(tick_cnt) < int'(step_reg) - 1) begin
                tick_cnt = tick_cnt + 1'b1;
            end else begin
                tick_cnt = '0;
                nxt = (int'(wr_ptr) + 1) % FIFO_DEPTH;
                // one slot stays free: a set that would fill the ring is lost
                if (nxt != int'(rd_ptr)) begin
                    for (ch = 0; ch < CHANNEL_COUNT; ch++)
                        ring_copy[wr_ptr][ch] = smp[ch];
                    wr_ptr = PTR_W'(nxt);
                end
            end
        end else begin
            held = (int'(wr_ptr) - int'(rd_ptr) + FIFO_DEPTH) % FIFO_DEPTH;
            if (link && step_reg != 0) begin
                if (pinned_on) begin
                    frames_due.push_back(pinned_frame);
                end else begin
                    for (k = 0; k < held; k++) begin
                        slot = (int'(rd_ptr) + k) % FIFO_DEPTH;
                        for (ch = 0; ch < OUT_CHANNELS; ch++) begin
                            if (ch < CHANNEL_COUNT) begin
                                ow  = (ch < 4) ? off_lo : off_hi;
                                gw  = (ch < 4) ? gain_lo : gain_hi;
                                s   = longint'($signed(ring_copy[slot][ch]));
                                o   = longint'($signed(ow[(ch % 4)*16 +: 16]));
                                g   = longint'($signed(gw[(ch % 4)*16 +: 16]));
                                acc = (s + o) * g + (longint'(OUT_BIAS) <<< FRAC_W);
                                if (acc < (longint'(BYTE_MIN) <<< FRAC_W))
                                    f.bytes[ch] = BYTE_W'(BYTE_MIN);
                                else if (acc >= (longint'(BYTE_MAX + 1) <<< FRAC_W))
                                    f.bytes[ch] = BYTE_W'(BYTE_MAX);
                                else
                                    f.bytes[ch] = BYTE_W'(acc >>> FRAC_W);
                            end else begin
                                f.bytes[ch] = '0;
                            end
                        end
                        f.last = (k == held - 1);
                        frames_due.push_back(f);
                    end
                end
            end
            rd_ptr = wr_ptr;
        end
    endtask

    always @(posedge aclk) begin : watch
        frame_t next_due;
        int     ch;
        if (!aresetn) begin
            step_reg = STEP_RESET;
            off_lo   = '0;
            off_hi   = '0;
            gain_lo  = GAIN_RESET;
            gain_hi  = GAIN_RESET;
            tick_cnt = '0;
            wr_ptr   = '0;
            rd_ptr   = '0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (frames_due.size() == 0) begin
                    flag_mismatch("unexpected frame", 0, m_tdata, '0);
                end else begin
                    next_due = frames_due.pop_front();
                    for (ch = 0; ch < OUT_CHANNELS; ch++)
                        if (m_tdata[ch*BYTE_W +: BYTE_W] !== next_due.bytes[ch])
                            flag_mismatch("byte", ch, 64'(m_tdata[ch*BYTE_W +: BYTE_W]),
                                          64'(next_due.bytes[ch]));
                    if (m_tlast !== next_due.last)
                        flag_mismatch("tlast", 0, 64'(m_tlast), 64'(next_due.last));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_DECIMATION_STEP: step_reg = cfg_wdata[TICK_W-1:0];
                    REG_OFFSETS_LOW:     off_lo   = cfg_wdata;
                    REG_OFFSETS_HIGH:    off_hi   = cfg_wdata;
                    REG_GAINS_LOW:       gain_lo  = cfg_wdata;
                    REG_GAINS_HIGH:      gain_hi  = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_framer_word(s_tuser[0], s_tuser[1], s_tdata);
        end
        cycle_no++;
        if (cycle_no > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver back-pressure: short random stalls, none while calm
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < 5) begin
            hold_left = $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic row_t tick_row(input logic link, input sample_set_t smp);
        row_t r;
        r      = '0;
        r.kind = ROW_TICK;
        r.link = link;
        r.smp  = smp;
        return r;
    endfunction

    function automatic row_t drain_row(input logic link, input logic pinned,
                                       input logic [BYTE_W-1:0] level);
        row_t r;
        r            = '0;
        r.kind       = ROW_DRAIN;
        r.link       = link;
        r.smp        = {$urandom, $urandom, $urandom, $urandom};
        r.pinned     = pinned;
        r.want.last  = 1'b1;
        r.want.bytes = {OUT_CHANNELS{level}};
        return r;
    endfunction

    function automatic row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
        row_t r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.val  = val;
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] lane_word(input int kind, input bit is_gain);
        logic [CFG_DATA_W-1:0] w;
        logic [15:0]           v;
        int                    i;
        for (i = 0; i < 4; i++) begin
            case (kind)
                LANES_ANY: v = 16'($urandom);
                LANES_MAX: v = 16'h7FFF;
                LANES_MIN: v = 16'h8000;
                default:   v = is_gain ? 16'($urandom_range(0, 1023) - 512)
                                       : 16'($urandom_range(0, 32767) - 16384);
            endcase
            w[i*16 +: 16] = v;
        end
        return w;
    endfunction

    task automatic offer_word(input row_t r);
        if (!calm && $urandom_range(0, 99) < 12) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge aclk);
        end
        s_tvalid     <= 1'b1;
        s_tuser      <= {r.link, (r.kind == ROW_DRAIN) ? OP_DRAIN : OP_TICK};
        s_tdata      <= r.smp;
        pinned_on    <= r.pinned;
        pinned_frame <= r.want;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // block idle: no frame owed, input side open, then the SETTLE wait for a silent drain
    task automatic settle_block();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (frames_due.size() != 0 || !s_tready);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
    endtask

    initial begin
        int          phase, quota, burst, k, sent, off_kind, gain_kind;
        logic [15:0] step_pick;
        sample_set_t mix_a, mix_b;

        mix_a = {16'hFF00, 16'h00FF, 16'hAAAA, 16'h5555,
                 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF};
        mix_b = {16'h00F0, 16'hF00F, 16'h5555, 16'hAAAA,
                 16'h0000, 16'hFFFE, 16'h7FFF, 16'h8001};

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings first: step 50, no offset, gain 10.0
        directed_rows.push_back(drain_row(1'b1, 1'b0, '0));            // empty ring
        directed_rows.push_back(tick_row(1'b1, {8{16'h1234}}));        // counted, not stored
        directed_rows.push_back(cfg_row(REG_DECIMATION_STEP, 64'd1));
        directed_rows.push_back(tick_row(1'b0, {8{16'h0000}}));
        directed_rows.push_back(drain_row(1'b1, 1'b1, 8'd128));
        directed_rows.push_back(tick_row(1'b0, {8{16'h7FFF}}));
        directed_rows.push_back(drain_row(1'b1, 1'b1, BYTE_W'(BYTE_MAX)));
        directed_rows.push_back(tick_row(1'b0, {8{16'h8000}}));
        directed_rows.push_back(drain_row(1'b1, 1'b1, BYTE_W'(BYTE_MIN)));
        directed_rows.push_back(tick_row(1'b0, {8{16'h0100}}));        // 1.0 * 10 + 128
        directed_rows.push_back(drain_row(1'b1, 1'b1, 8'd138));
        directed_rows.push_back(tick_row(1'b0, mix_a));
        directed_rows.push_back(tick_row(1'b1, mix_b));
        directed_rows.push_back(drain_row(1'b1, 1'b0, '0));
        directed_rows.push_back(tick_row(1'b0, mix_a));
        directed_rows.push_back(drain_row(1'b0, 1'b0, '0));            // link down: discard
        directed_rows.push_back(cfg_row(REG_DECIMATION_STEP, 64'd0));
        directed_rows.push_back(tick_row(1'b0, mix_b));
        directed_rows.push_back(tick_row(1'b0, mix_a));
        directed_rows.push_back(drain_row(1'b1, 1'b0, '0));            // step 0: no output
        directed_rows.push_back(cfg_row(REG_DECIMATION_STEP, 64'd5));
        directed_rows.push_back(tick_row(1'b0, mix_a));
        directed_rows.push_back(tick_row(1'b0, mix_b));
        directed_rows.push_back(tick_row(1'b0, mix_a));
        // step dropped under the running count: next tick stores
        directed_rows.push_back(cfg_row(REG_DECIMATION_STEP, 64'd2));
        directed_rows.push_back(tick_row(1'b0, mix_b));
        directed_rows.push_back(tick_row(1'b0, mix_a));
        directed_rows.push_back(drain_row(1'b1, 1'b0, '0));
        directed_rows.push_back(cfg_row(REG_OFFSETS_LOW,  {4{16'h7FFF}}));
        directed_rows.push_back(cfg_row(REG_OFFSETS_HIGH, {4{16'h8000}}));
        directed_rows.push_back(cfg_row(REG_GAINS_LOW,    {4{16'h8000}}));
        directed_rows.push_back(cfg_row(REG_GAINS_HIGH,   {4{16'h7FFF}}));
        directed_rows.push_back(cfg_row(REG_SPARE_LO,     64'hFFFF_FFFF_FFFF_FFFF));
        directed_rows.push_back(cfg_row(CFG_INDEX_W'(REG_SPARE_LO + 1), 64'h0));
        directed_rows.push_back(cfg_row(CFG_INDEX_W'(REG_SPARE_LO + 2),
                                        64'h5A5A_A5A5_0F0F_F0F0));
        directed_rows.push_back(tick_row(1'b0, {8{16'h7FFF}}));
        directed_rows.push_back(tick_row(1'b0, {8{16'h8000}}));
        directed_rows.push_back(tick_row(1'b1, {8{16'h8000}}));
        directed_rows.push_back(drain_row(1'b1, 1'b0, '0));

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                settle_block();
                write_reg(directed_rows[i].idx, directed_rows[i].val);
                cfg_wr_en <= 1'b0;
            end else begin
                offer_word(directed_rows[i]);
            end
        end

        sent = 0;
        for (phase = 0; sent < RAND_ITEMS; phase++) begin
            case (phase)
                0:       step_pick = 16'd1;
                1:       step_pick = 16'd3;
                2:       step_pick = 16'd2;
                3:       step_pick = 16'd0;
                4:       step_pick = 16'hFFFF;
                default: step_pick = $urandom_range(1, 6);
            endcase
            case (phase)
                4: begin
                    off_kind  = LANES_ANY;
                    gain_kind = LANES_ANY;
                end
                5: begin
                    off_kind  = LANES_MAX;
                    gain_kind = LANES_MIN;
                end
                6: begin
                    off_kind  = LANES_MIN;
                    gain_kind = LANES_MAX;
                end
                default: begin
                    off_kind  = ($urandom_range(0, 3) == 0) ? LANES_ANY : LANES_MILD;
                    gain_kind = ($urandom_range(0, 3) == 0) ? LANES_ANY : LANES_MILD;
                end
            endcase
            settle_block();
            write_reg(REG_DECIMATION_STEP, CFG_DATA_W'(step_pick));
            write_reg(REG_OFFSETS_LOW, lane_word(off_kind, 1'b0));
            write_reg(REG_OFFSETS_HIGH, lane_word(off_kind, 1'b0));
            write_reg(REG_GAINS_LOW, lane_word(gain_kind, 1'b1));
            write_reg(REG_GAINS_HIGH, lane_word(gain_kind, 1'b1));
            write_reg(REG_SPARE_LO + CFG_INDEX_W'($urandom_range(0, 2)), {$urandom, $urandom});
            cfg_wr_en <= 1'b0;

            calm  = (phase == 2);
            quota = sent + PHASE_ITEMS;
            while (sent < quota) begin
                // first burst overfills the ring; later ones do so now and then
                if (phase == 0 && sent == 0)
                    burst = FIFO_DEPTH + 2;
                else if ($urandom_range(0, 99) < 5)
                    burst = FIFO_DEPTH + 6;
                else
                    burst = $urandom_range(0, 12);
                for (k = 0; k < burst; k++) begin
                    offer_word(tick_row(1'($urandom),
                                        {$urandom, $urandom, $urandom, $urandom}));
                    sent++;
                end
                offer_word(drain_row($urandom_range(0, 99) < 85, 1'b0, '0));
                sent++;
            end
        end
        calm = 1'b0;

        settle_block();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
